// ----- rtl/itad_pkg.sv -----
// ----------------------------------------------------------------------------
// itad_pkg: shared types and constants for integer_to_ascii_digits
// Holds the job and digit word formats, mode codes and ASCII constants.
// ----------------------------------------------------------------------------
package itad_pkg;

    localparam int VALUE_W   = 64;
    localparam int ACTION_W  = 2;
    localparam int CHAR_W    = 7;
    localparam int DIGIT_W   = 4;
    localparam int NUM_DIGITS = 20;
    localparam int BCD_W     = NUM_DIGITS * DIGIT_W;
    localparam int POS_W     = $clog2(NUM_DIGITS + 1);

    // Binary to BCD: bits folded in per cycle and the resulting pass count
    localparam int BITS_PER_CYCLE = 4;
    localparam int CONV_ITERS     = VALUE_W / BITS_PER_CYCLE;
    localparam int CONV_CNT_W     = $clog2(CONV_ITERS);

    // Job queue between the front and the converter
    localparam int QDEPTH = 2;
    localparam int Q_AW   = $clog2(QDEPTH);
    localparam int Q_CW   = $clog2(QDEPTH + 1);

    // Mode codes; any code with the high bit set selects hexadecimal
    localparam logic [ACTION_W-1:0] MODE_UDEC = 2'd0;
    localparam logic [ACTION_W-1:0] MODE_SDEC = 2'd1;
    localparam int                  MODE_HEX_BIT = 1;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWA  = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX_DEC = 4'd9;

    typedef struct packed {
        logic               hex;
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_job;

    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] digits;
    } t_digits;

endpackage

// ----- rtl/itad_front.sv -----
// ----------------------------------------------------------------------------
// itad_front: input acceptance, classification and job queue
// Decodes the mode, takes the magnitude of negative signed values and
// queues the job for the converter.
// ----------------------------------------------------------------------------
module itad_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [itad_pkg::ACTION_W-1:0]     i_action,
    input  logic [itad_pkg::VALUE_W-1:0]      i_value,
    output logic                              o_job_valid,
    input  logic                              i_job_ready,
    output itad_pkg::t_job                    o_job
);
    import itad_pkg::*;

    t_job            r_mem [QDEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_CW-1:0] r_count;
    t_job            n_job;
    logic            push, pop;

    always_comb begin
        n_job.hex = i_action[MODE_HEX_BIT];
        n_job.neg = (i_action == MODE_SDEC) && i_value[VALUE_W-1];
        n_job.mag = n_job.neg ? (~i_value + VALUE_W'(1)) : i_value;
    end

    assign o_ready     = (r_count != Q_CW'(QDEPTH));
    assign push        = i_valid && o_ready;
    assign o_job_valid = (r_count != '0);
    assign pop         = o_job_valid && i_job_ready;
    assign o_job       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= n_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == Q_AW'(QDEPTH - 1)) ? '0 : r_wr + Q_AW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == Q_AW'(QDEPTH - 1)) ? '0 : r_rd + Q_AW'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + Q_CW'(1);
                2'b01:   r_count <= r_count - Q_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(QDEPTH))
        else $error("job queue count out of range");
`endif

endmodule

// ----- rtl/itad_conv.sv -----
// ----------------------------------------------------------------------------
// itad_conv: binary to digit conversion
// Decimal jobs run a shift-add-3 pass, four bits per cycle; hex jobs load
// their nibbles directly.
// ----------------------------------------------------------------------------
module itad_conv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    output logic                o_job_ready,
    input  itad_pkg::t_job      i_job,
    output logic                o_dig_valid,
    input  logic                i_dig_ready,
    output itad_pkg::t_digits   o_dig
);
    import itad_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]            r_state;
    logic [CONV_CNT_W-1:0] r_cnt;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic [VALUE_W-1:0]    r_bin, n_bin;
    logic                  r_neg;

    // Four dependent add-3 and shift steps on the digit register
    always_comb begin
        n_bcd = r_bcd;
        n_bin = r_bin;
        for (int s = 0; s < BITS_PER_CYCLE; s++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (n_bcd[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                    n_bcd[d*DIGIT_W +: DIGIT_W] = n_bcd[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
                end
            end
            {n_bcd, n_bin} = {n_bcd, n_bin} << 1;
        end
    end

    assign o_job_ready = (r_state == ST_IDLE);
    assign o_dig_valid = (r_state == ST_DONE);
    assign o_dig.neg    = r_neg;
    assign o_dig.digits = r_bcd;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_job_valid) begin
            r_neg <= i_job.neg;
            r_bin <= i_job.mag;
            r_bcd <= i_job.hex ? BCD_W'(i_job.mag) : '0;
        end else if (r_state == ST_RUN) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (i_job_valid) begin
                        r_state <= i_job.hex ? ST_DONE : ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_cnt <= r_cnt + CONV_CNT_W'(1);
                    if (r_cnt == CONV_CNT_W'(CONV_ITERS - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (i_dig_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_done_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE |=> r_state == ST_DONE || r_state == ST_IDLE)
        else $error("converter left done state other than to idle");
`endif

endmodule

// ----- rtl/itad_emit.sv -----
// ----------------------------------------------------------------------------
// itad_emit: character emitter
// Walks the digit word from the top, drops leading zeros, and drives the
// registered character output with the last flag.
// ----------------------------------------------------------------------------
module itad_emit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_dig_valid,
    output logic                            o_dig_ready,
    input  itad_pkg::t_digits               i_dig,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [itad_pkg::CHAR_W-1:0]     o_character,
    output logic                            o_last
);
    import itad_pkg::*;

    logic               r_busy, r_neg, r_started, r_ovalid;
    logic [POS_W-1:0]   r_pos;
    logic [BCD_W-1:0]   r_bcd;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    logic [DIGIT_W-1:0] top;
    logic               out_free, is_last, do_skip, do_minus, do_digit;
    logic [CHAR_W-1:0]  digit_char;

    assign top      = r_bcd[BCD_W-1 -: DIGIT_W];
    assign out_free = !r_ovalid || i_ready;
    assign is_last  = (r_pos == POS_W'(1));
    assign do_minus = r_busy && r_neg && out_free;
    assign do_skip  = r_busy && !r_neg && !r_started && (top == '0) && !is_last;
    assign do_digit = r_busy && !r_neg && !do_skip && out_free;

    assign digit_char = (top > DIGIT_MAX_DEC)
                      ? CHAR_LOWA + CHAR_W'(top) - CHAR_W'(10)
                      : CHAR_ZERO + CHAR_W'(top);

    assign o_dig_ready = !r_busy;
    assign o_valid     = r_ovalid;
    assign o_character = r_char;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_dig_valid) begin
            r_bcd <= i_dig.digits;
        end else if (do_skip || do_digit) begin
            r_bcd <= r_bcd << DIGIT_W;
        end
        if (do_minus) begin
            r_char <= CHAR_MINUS;
            r_last <= 1'b0;
        end else if (do_digit) begin
            r_char <= digit_char;
            r_last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_neg     <= 1'b0;
            r_started <= 1'b0;
            r_pos     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (!r_busy) begin
                if (i_dig_valid) begin
                    r_busy    <= 1'b1;
                    r_neg     <= i_dig.neg;
                    r_started <= 1'b0;
                    r_pos     <= POS_W'(NUM_DIGITS);
                end
            end else if (do_minus) begin
                r_neg <= 1'b0;
            end else if (do_skip) begin
                r_pos <= r_pos - POS_W'(1);
            end else if (do_digit) begin
                r_pos     <= r_pos - POS_W'(1);
                r_started <= 1'b1;
                if (is_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (do_minus || do_digit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pos != '0) && (r_pos <= POS_W'(NUM_DIGITS)))
        else $error("digit position out of range while busy");
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && (r_char == CHAR_MINUS) |-> !r_last)
        else $error("minus sign flagged as last character");
`endif

endmodule

// ----- rtl/integer_to_ascii_digits.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_digits: 64-bit integer to ASCII text
// Converts one number per input word into its characters, most significant
// first, one character per output word.
// ----------------------------------------------------------------------------
// Each input word carries a 64-bit value and a mode: 0 prints unsigned
// decimal, 1 signed decimal (a leading '-' then the magnitude; the most
// negative value prints as 9223372036854775808), 2 or 3 lowercase hex with
// no prefix and no padding. Zero prints as a single '0'. Every character
// leaves as its own output word and o_last marks the final one. The block
// has three parts: a front that classifies the word and takes the magnitude,
// a two-entry job queue, and a back made of a converter and an emitter. The
// converter runs a shift-add-3 binary to BCD pass at four bits a cycle; hex
// values load in directly. The emitter then walks all 20 digit positions one
// per cycle while the output is not stalled, dropping leading zeros, plus a
// step for a minus sign and one to load the next digit word. Conversion of
// the next number overlaps emission of the current one, so the sustained
// rate is set by the emitter when the output is never stalled. The output
// is registered, so the front keeps taking words while a character waits.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [itad_pkg::ACTION_W-1:0]   i_action,
    input  logic [itad_pkg::VALUE_W-1:0]    i_value,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [itad_pkg::CHAR_W-1:0]     o_character,
    output logic                            o_last
);
    import itad_pkg::*;

    // Front to converter: classified job word
    t_job    job;
    logic    job_valid, job_ready;
    // Converter to emitter: finished digit word
    t_digits dig;
    logic    dig_valid, dig_ready;

    // Accept, classify and queue
    itad_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_value     (i_value),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    // Build the digit word
    itad_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_dig_valid (dig_valid),
        .i_dig_ready (dig_ready),
        .o_dig       (dig)
    );

    // Drop leading zeros and drive characters out
    itad_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dig_valid (dig_valid),
        .o_dig_ready (dig_ready),
        .i_dig       (dig),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

// ----- sim/tb_integer_to_ascii_digits.sv -----
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_digits: self-checking bench for integer_to_ascii_digits
// Feeds numbers in all modes with random gaps and output stalls, predicts
// each character of the printed text and checks every output word in order.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_digits;
    import itad_pkg::*;

    // Hex is selected by the high mode bit, so both upper codes print hex
    localparam logic [ACTION_W-1:0] MODE_HEX     = 2'd2;
    localparam logic [ACTION_W-1:0] MODE_HEX_ALT = 2'd3;

    localparam logic [VALUE_W-1:0] DEC_RADIX = 64'd10;
    localparam logic [VALUE_W-1:0] HEX_RADIX = 64'd16;
    localparam logic [VALUE_W-1:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] MOST_NEG  = 64'h8000_0000_0000_0000;
    localparam logic [VALUE_W-1:0] MOST_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] TEN_POW19 = 64'd10000000000000000000;

    localparam int RANDOM_NUMBERS = 360;
    localparam int MAX_PAUSE      = 18;
    localparam int DRAIN_CYCLES   = 64;
    localparam int CYCLE_LIMIT    = 1_000_000;

    typedef struct packed {
        logic [ACTION_W-1:0] mode;
        logic [VALUE_W-1:0]  value;
    } t_number;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [ACTION_W-1:0] i_action;
    logic [VALUE_W-1:0]  i_value;
    logic                o_valid;
    logic                i_ready;
    logic [CHAR_W-1:0]   o_character;
    logic                o_last;

    t_number     pending_numbers[$];
    t_char       expected_chars[$];
    int unsigned numbers_sent;
    int unsigned chars_seen;
    int unsigned send_pause;
    int unsigned recv_pause;
    int unsigned mismatch_cnt;
    int unsigned cycle_cnt;

    integer_to_ascii_digits u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Queue the characters the number should print, most significant first
    function automatic void predict_text(logic [ACTION_W-1:0] mode, logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] radix;
        logic [DIGIT_W-1:0] digs[NUM_DIGITS];
        logic               neg;
        logic [CHAR_W-1:0]  code;
        int                 nd;
        mag = value;
        neg = 1'b0;
        nd  = 0;
        if (mode[MODE_HEX_BIT]) begin
            radix = HEX_RADIX;
        end else begin
            radix = DEC_RADIX;
            // Negate in 64 bits; the most negative value stays as its magnitude
            if (mode == MODE_SDEC && value[VALUE_W-1]) begin
                neg = 1'b1;
                mag = ~value + 64'd1;
            end
        end
        // Zero still yields one digit
        do begin
            digs[nd] = DIGIT_W'(mag % radix);
            mag      = mag / radix;
            nd++;
        end while (mag != 0);
        if (neg)
            expected_chars.push_back('{code: CHAR_MINUS, last: 1'b0});
        for (int i = nd - 1; i >= 0; i--) begin
            if (digs[i] > DIGIT_MAX_DEC)
                code = CHAR_LOWA + CHAR_W'(digs[i] - 4'd10);
            else
                code = CHAR_ZERO + CHAR_W'(digs[i]);
            expected_chars.push_back('{code: code, last: (i == 0)});
        end
    endfunction

    // Drop idling entirely during quiet stretches, else draw a random pause up to MAX_PAUSE
    function automatic int unsigned draw_pause(bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_PAUSE);
    endfunction

    // Driver: hold the word until taken, then advance after a random pause
    always @(posedge i_clk) begin : number_driver
        int unsigned wait_now;
        t_number     next_num;
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            send_pause <= 0;
        end else if (!(i_valid && !o_ready)) begin
            if (i_valid) begin
                predict_text(i_action, i_value);
                numbers_sent++;
                wait_now = draw_pause((numbers_sent / 40) % 3 == 1);
            end else begin
                wait_now = send_pause;
            end
            if (wait_now == 0 && pending_numbers.size() != 0) begin
                next_num    = pending_numbers.pop_front();
                i_action   <= next_num.mode;
                i_value    <= next_num.value;
                i_valid    <= 1'b1;
                send_pause <= 0;
            end else begin
                i_valid    <= 1'b0;
                send_pause <= (wait_now > 0) ? wait_now - 1 : 0;
            end
        end
    end

    // Monitor: check each taken character against the oldest prediction
    always @(posedge i_clk) begin : text_monitor
        t_char       due;
        int unsigned stall;
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            recv_pause <= 0;
        end else begin
            if (o_valid && i_ready) begin
                chars_seen++;
                if (expected_chars.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected word char=%h last=%b", $time, o_character, o_last);
                end else begin
                    due = expected_chars.pop_front();
                    if (o_character !== due.code) begin
                        mismatch_cnt++;
                        $display("%0t: character expected %h actual %h",
                                 $time, due.code, o_character);
                    end
                    if (o_last !== due.last) begin
                        mismatch_cnt++;
                        $display("%0t: last expected %b actual %b", $time, due.last, o_last);
                    end
                end
                stall = draw_pause((chars_seen / 150) % 3 == 2);
                i_ready    <= (stall == 0);
                recv_pause <= (stall > 0) ? stall - 1 : 0;
            end else if (!i_ready) begin
                i_ready    <= (recv_pause == 0);
                recv_pause <= (recv_pause > 0) ? recv_pause - 1 : 0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        logic [ACTION_W-1:0] mode;
        logic [VALUE_W-1:0]  value;
        int                  k;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_ready      <= 1'b0;
        i_action     <= MODE_UDEC;
        i_value      <= '0;
        cycle_cnt    = 0;
        numbers_sent = 0;
        chars_seen   = 0;
        mismatch_cnt = 0;

        // Zero in every mode, never with a minus sign
        pending_numbers.push_back('{MODE_UDEC, 64'd0});
        pending_numbers.push_back('{MODE_SDEC, 64'd0});
        pending_numbers.push_back('{MODE_HEX, 64'd0});
        pending_numbers.push_back('{MODE_HEX_ALT, 64'd0});
        // Longest texts and the all-ones pattern
        pending_numbers.push_back('{MODE_UDEC, ALL_ONES});
        pending_numbers.push_back('{MODE_SDEC, ALL_ONES});
        pending_numbers.push_back('{MODE_HEX, ALL_ONES});
        pending_numbers.push_back('{MODE_HEX_ALT, ALL_ONES});
        // Most negative value prints its unsigned magnitude
        pending_numbers.push_back('{MODE_SDEC, MOST_NEG});
        pending_numbers.push_back('{MODE_UDEC, MOST_NEG});
        pending_numbers.push_back('{MODE_HEX, MOST_NEG});
        pending_numbers.push_back('{MODE_SDEC, MOST_POS});
        pending_numbers.push_back('{MODE_SDEC, MOST_NEG + 64'd1});
        // Digit count boundaries
        pending_numbers.push_back('{MODE_UDEC, TEN_POW19});
        pending_numbers.push_back('{MODE_UDEC, TEN_POW19 - 64'd1});
        pending_numbers.push_back('{MODE_UDEC, 64'd9});
        pending_numbers.push_back('{MODE_UDEC, 64'd10});
        pending_numbers.push_back('{MODE_HEX, 64'd15});
        pending_numbers.push_back('{MODE_HEX, 64'd16});
        pending_numbers.push_back('{MODE_HEX, 64'h0123_4567_89AB_CDEF});
        pending_numbers.push_back('{MODE_HEX_ALT, 64'hFEDC_BA98_7654_3210});
        pending_numbers.push_back('{MODE_SDEC, 64'd1});

        for (int n = 0; n < RANDOM_NUMBERS; n++) begin
            mode = ACTION_W'($urandom_range(0, 3));
            case ($urandom_range(0, 4))
                0: value = {$urandom, $urandom};
                1: value = 64'($urandom_range(0, 1000));
                2: value = {$urandom, $urandom} >> $urandom_range(1, 63);
                3: begin
                    // Around a power of two: one below, at, one above
                    k     = $urandom_range(0, 63);
                    value = (64'd1 << k) + 64'($urandom_range(0, 2)) - 64'd1;
                end
                default: value = ~64'($urandom_range(0, 100000)) + 64'd1;
            endcase
            pending_numbers.push_back('{mode, value});
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_numbers.size() != 0 || i_valid || expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/itad_pkg.sv
rtl/itad_front.sv
rtl/itad_conv.sv
rtl/itad_emit.sv
rtl/integer_to_ascii_digits.sv
sim/tb_integer_to_ascii_digits.sv
